// ===== src/wvrs_pkg.sv =====
`timescale 1ns / 1ps

package wvrs_pkg;

  // Encoder accumulator width; the fine setpoint carries eight fraction bits more.
  localparam int unsigned ENCODER_BITS = 32;
  localparam int unsigned FINE_BITS    = ENCODER_BITS + 8;
  localparam int unsigned COUNT_BITS   = 32;
  localparam int unsigned SPEED_BITS   = 16;
  localparam int unsigned DELTA_BITS   = 8;
  localparam int unsigned CFG_BITS     = 16;
  localparam int unsigned REG_IDX_BITS = 2;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_LINEAR_ACCEL   = 2'd0,
    REG_ANGULAR_ACCEL  = 2'd1,
    REG_LINEAR_TARGET  = 2'd2,
    REG_ANGULAR_TARGET = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic        [SPEED_BITS-1:0] linear_accel;
    logic        [SPEED_BITS-1:0] angular_accel;
    logic signed [SPEED_BITS-1:0] linear_target;
    logic signed [SPEED_BITS-1:0] angular_target;
  } cfg_t;

  typedef struct packed {
    logic signed [SPEED_BITS-1:0] position_error_target;
    logic signed [COUNT_BITS-1:0] encoder_count;
    logic signed [SPEED_BITS-1:0] step_velocity;
  } result_t;

  // Move a speed towards its target by at most accel, never passing the target.
  function automatic logic signed [SPEED_BITS-1:0] ramp(
    input logic signed [SPEED_BITS-1:0] speed,
    input logic signed [SPEED_BITS-1:0] target,
    input logic        [SPEED_BITS-1:0] accel
  );
    logic signed [SPEED_BITS+1:0] speed_w;
    logic signed [SPEED_BITS+1:0] target_w;
    logic signed [SPEED_BITS+1:0] accel_w;
    logic signed [SPEED_BITS+1:0] moved;
    logic signed [SPEED_BITS-1:0] res;
    speed_w  = (SPEED_BITS+2)'(speed);
    target_w = (SPEED_BITS+2)'(target);
    accel_w  = signed'({2'b00, accel});
    res      = speed;
    moved    = speed_w;
    if (speed_w < target_w) begin
      moved = speed_w + accel_w;
      res   = (moved > target_w) ? target : moved[SPEED_BITS-1:0];
    end else if (speed_w > target_w) begin
      moved = speed_w - accel_w;
      res   = (moved < target_w) ? target : moved[SPEED_BITS-1:0];
    end
    return res;
  endfunction

  // Fine setpoint over 256, rounded towards zero.
  function automatic logic signed [ENCODER_BITS-1:0] div256(
    input logic signed [FINE_BITS-1:0] fine
  );
    logic signed [ENCODER_BITS-1:0] q;
    q = fine[FINE_BITS-1:8];
    if (fine[FINE_BITS-1] && (fine[7:0] != 8'd0)) begin
      q = q + ENCODER_BITS'(1);
    end
    return q;
  endfunction

endpackage

// ===== src/wvrs_core.sv =====
`timescale 1ns / 1ps

module wvrs_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               update_i,
  input  logic signed [wvrs_pkg::DELTA_BITS-1:0] delta_i,
  input  wvrs_pkg::cfg_t                     cfg_i,
  output wvrs_pkg::result_t                  result_o
);
  import wvrs_pkg::*;

  logic signed [ENCODER_BITS-1:0] enc_q, enc_d;
  logic signed [FINE_BITS-1:0]    fine_q, fine_d;
  logic signed [SPEED_BITS-1:0]   lin_q, lin_d;
  logic signed [SPEED_BITS-1:0]   ang_q, ang_d;

  logic signed [SPEED_BITS:0]     speed_sum;
  logic signed [SPEED_BITS-1:0]   step;
  logic signed [SPEED_BITS:0]     step_ext;
  logic signed [SPEED_BITS:0]     step_x2;
  logic        [SPEED_BITS:0]     abs_step;
  logic signed [ENCODER_BITS-1:0] quot_old, quot_new;
  logic signed [SPEED_BITS-1:0]   err;
  logic signed [SPEED_BITS:0]     err_ext;
  logic        [SPEED_BITS:0]     abs_err;
  logic signed [FINE_BITS-1:0]    base;
  logic                           step_wins;
  logic                           same_sign;

  always_comb begin
    enc_d = enc_q + ENCODER_BITS'(delta_i);
    lin_d = ramp(lin_q, cfg_i.linear_target, cfg_i.linear_accel);
    ang_d = ramp(ang_q, cfg_i.angular_target, cfg_i.angular_accel);

    // Saturating sum of the two ramped speeds.
    speed_sum = (SPEED_BITS+1)'(lin_d) + (SPEED_BITS+1)'(ang_d);
    if (speed_sum[SPEED_BITS] != speed_sum[SPEED_BITS-1]) begin
      step = speed_sum[SPEED_BITS] ? signed'({1'b1, {(SPEED_BITS-1){1'b0}}})
                                   : signed'({1'b0, {(SPEED_BITS-1){1'b1}}});
    end else begin
      step = speed_sum[SPEED_BITS-1:0];
    end
    step_ext = (SPEED_BITS+1)'(step);
    step_x2  = {step, 1'b0};
    abs_step = step_ext[SPEED_BITS] ? unsigned'(-step_ext) : unsigned'(step_ext);

    // Following error seen against the old setpoint and the new encoder count.
    quot_old = div256(fine_q);
    err      = quot_old[SPEED_BITS-1:0] - enc_d[SPEED_BITS-1:0];
    err_ext  = (SPEED_BITS+1)'(err);
    abs_err  = err_ext[SPEED_BITS] ? unsigned'(-err_ext) : unsigned'(err_ext);

    step_wins = ({8'd0, abs_step} > {abs_err, 8'd0});
    same_sign = (step != '0) && (err != '0) && (step[SPEED_BITS-1] == err[SPEED_BITS-1]);
    base      = {enc_d, 8'd0};

    priority if (step_wins) begin
      fine_d = fine_q + FINE_BITS'(step);
    end else if (same_sign) begin
      fine_d = base + FINE_BITS'(step_x2);
    end else begin
      fine_d = base;
    end

    quot_new = div256(fine_d);
    result_o.position_error_target = quot_new[SPEED_BITS-1:0] - enc_d[SPEED_BITS-1:0];
    result_o.encoder_count         = COUNT_BITS'(enc_d);
    result_o.step_velocity         = step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_q  <= '0;
      fine_q <= '0;
      lin_q  <= '0;
      ang_q  <= '0;
    end else if (update_i) begin
      enc_q  <= enc_d;
      fine_q <= fine_d;
      lin_q  <= lin_d;
      ang_q  <= ang_d;
    end
  end

endmodule

// ===== src/wheel_velocity_ramp_setpoint.sv =====
`timescale 1ns / 1ps

// Wheel velocity ramp and position setpoint generator. Each input transaction
// carries the encoder delta of one update tick and produces exactly one output
// transaction: the position error target for the PID, the accumulated encoder
// count and the saturated step velocity used in the setpoint update. The
// block takes one transaction per clock cycle while the output side is not
// stalled. An accepted input transaction is held in the input register and
// passes through the update logic into the output register once that register
// is empty or is being emptied; output valid is registered. The state update
// (ramp, saturating sum, run-away clamp and setpoint add) is combinational
// between those two registers. The four configuration registers (linear and
// angular acceleration, linear and angular target) are written through a plain
// write port and should only be changed while no transaction is in flight.

module wheel_velocity_ramp_setpoint (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration write port.
  input  logic                                   cfg_we_i,
  input  logic [wvrs_pkg::REG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [wvrs_pkg::CFG_BITS-1:0]          cfg_wdata_i,
  // Input channel.
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [wvrs_pkg::DELTA_BITS-1:0] encoder_delta_i,
  // Output channel.
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [wvrs_pkg::SPEED_BITS-1:0] position_error_target_o,
  output logic signed [wvrs_pkg::COUNT_BITS-1:0] encoder_count_o,
  output logic signed [wvrs_pkg::SPEED_BITS-1:0] step_velocity_o
);
  import wvrs_pkg::*;

  cfg_t    cfg_q;
  logic    s1_valid_q;
  logic signed [DELTA_BITS-1:0] delta_q;
  logic    out_valid_q;
  result_t result_q;
  result_t result_d;
  logic    in_fire;
  logic    advance;

  // Configuration registers. All four indices are in use, so every write lands.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_LINEAR_ACCEL:   cfg_q.linear_accel   <= cfg_wdata_i;
        REG_ANGULAR_ACCEL:  cfg_q.angular_accel  <= cfg_wdata_i;
        REG_LINEAR_TARGET:  cfg_q.linear_target  <= signed'(cfg_wdata_i);
        REG_ANGULAR_TARGET: cfg_q.angular_target <= signed'(cfg_wdata_i);
      endcase
    end
  end

  // The input register advances into the output register whenever the output
  // register is empty or is being emptied in the same cycle. The controller
  // state is committed at that moment, so transactions update it strictly in
  // order of arrival.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  wvrs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (advance),
    .delta_i  (delta_q),
    .cfg_i    (cfg_q),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      delta_q <= encoder_delta_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign position_error_target_o = result_q.position_error_target;
  assign encoder_count_o         = result_q.encoder_count;
  assign step_velocity_o         = result_q.step_velocity;

endmodule

// ===== src/wvrs_checker.sv =====
`timescale 1ns / 1ps

module wvrs_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_ready_o,
  input logic                                   out_valid_o,
  input logic                                   out_ready_i,
  input logic signed [wvrs_pkg::SPEED_BITS-1:0] position_error_target_o,
  input logic signed [wvrs_pkg::COUNT_BITS-1:0] encoder_count_o,
  input logic signed [wvrs_pkg::SPEED_BITS-1:0] step_velocity_o
);
  import wvrs_pkg::*;

  // A waiting result holds its value until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(position_error_target_o)
      && $stable(encoder_count_o) && $stable(step_velocity_o))
    else $error("output transaction changed while stalled");

  // A result only appears after an input was taken and registered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("output appeared without a matching input");

  // With the consumer ready the pipeline can always take a new input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled although the output side is draining");

  // A zero step always rebases the setpoint onto the encoder.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (step_velocity_o == '0) |-> (position_error_target_o == '0))
    else $error("nonzero error target with zero step velocity");

endmodule

bind wheel_velocity_ramp_setpoint wvrs_checker u_wvrs_checker (
  .clk_i                   (clk_i),
  .rst_ni                  (rst_ni),
  .in_valid_i              (in_valid_i),
  .in_ready_o              (in_ready_o),
  .out_valid_o             (out_valid_o),
  .out_ready_i             (out_ready_i),
  .position_error_target_o (position_error_target_o),
  .encoder_count_o         (encoder_count_o),
  .step_velocity_o         (step_velocity_o)
);
